>>> rtl/ila_pkg.sv
// ----------------------------------------------------------------------------
// ila_pkg
// Shared types and constants for the indexed insert/erase list.
// ----------------------------------------------------------------------------
package ila_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int DATA_W       = 32;
   localparam int POS_W        = 6;
   localparam int CNT_W        = 6;
   localparam int FUNC_W       = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SHIFT,
      ST_INS_PUT,
      ST_ERA_SHIFT,
      ST_LIST
   } ctl_state_type;

   typedef struct packed {
      logic load_ins;
      logic load_era;
      logic load_list;
      logic ins_step;
      logic ins_put;
      logic era_step;
      logic list_step;
      logic rsp_fail;
      logic rsp_empty;
   } ctl_cmd_type;

   typedef struct packed {
      logic ins_ok;
      logic era_ok;
      logic empty;
      logic at_pos;
      logic at_fill;
   } dp_status_type;

endpackage

>>> rtl/ila_ram.sv
// ----------------------------------------------------------------------------
// ila_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ila_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ila_ctl.sv
// ----------------------------------------------------------------------------
// ila_ctl
// Sequencer for insert, erase and list requests.
// ----------------------------------------------------------------------------
module ila_ctl
   import ila_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FUNC_W-1:0] req_func,
   input  dp_status_type     stat,
   output logic              busy,
   output ctl_cmd_type       cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (req_func)
                  FUNC_INSERT: begin
                     if (stat.ins_ok) begin
                        cmd.load_ins = 1'b1;
                        state_in     = ST_INS_SHIFT;
                     end else begin
                        cmd.rsp_fail = 1'b1;
                     end
                  end
                  FUNC_ERASE: begin
                     if (stat.era_ok) begin
                        cmd.load_era = 1'b1;
                        state_in     = ST_ERA_SHIFT;
                     end else begin
                        cmd.rsp_fail = 1'b1;
                     end
                  end
                  FUNC_LIST: begin
                     if (stat.empty) begin
                        cmd.rsp_empty = 1'b1;
                     end else begin
                        cmd.load_list = 1'b1;
                        state_in      = ST_LIST;
                     end
                  end
                  default: begin
                     cmd.rsp_fail = 1'b1;
                  end
               endcase
            end
         end
         ST_INS_SHIFT: begin
            cmd.ins_step = 1'b1;
            if (stat.at_pos) begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            cmd.ins_put = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_ERA_SHIFT: begin
            cmd.era_step = 1'b1;
            if (stat.at_fill) begin
               state_in = ST_IDLE;
            end
         end
         ST_LIST: begin
            cmd.list_step = 1'b1;
            if (stat.at_fill) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/ila_dp.sv
// ----------------------------------------------------------------------------
// ila_dp
// Entry memory, fill count, walk pointer and result registers.
// ----------------------------------------------------------------------------
module ila_dp
   import ila_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_cmd_type              cmd,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output dp_status_type            stat,
   output logic                     rsp_strobe,
   output logic                     rsp_ok,
   output logic [CNT_W-1:0]         rsp_count,
   output logic signed [DATA_W-1:0] rsp_item,
   output logic                     rsp_item_valid,
   output logic                     rsp_last
);

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1;

   logic [FW-1:0]     fill_ff, fill_in;
   logic [FW-1:0]     ptr_ff, ptr_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              rd_vld_ff, rd_vld_in;

   logic              strobe_ff, strobe_in;
   logic              ok_ff, ok_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] item_ff, item_in;
   logic              ivld_ff, ivld_in;
   logic              last_ff, last_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic [CW-1:0]     fill_x, ptr_x, req_pos_x, pos_x;

   ila_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign fill_x    = CW'(fill_ff);
   assign ptr_x     = CW'(ptr_ff);
   assign req_pos_x = CW'(req_position);
   assign pos_x     = CW'(pos_ff);

   always_comb begin
      stat.ins_ok  = (req_pos_x <= fill_x) && (fill_x < CW'(CAPACITY));
      stat.era_ok  = req_pos_x < fill_x;
      stat.empty   = fill_ff == '0;
      stat.at_pos  = ptr_x == pos_x;
      stat.at_fill = ptr_ff == fill_ff;
   end

   always_comb begin
      fill_in   = fill_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      rd_vld_in = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = '0;
      strobe_in = 1'b0;
      ok_in     = ok_ff;
      cnt_in    = cnt_ff;
      item_in   = item_ff;
      ivld_in   = ivld_ff;
      last_in   = last_ff;

      if (cmd.load_ins) begin
         pos_in = req_position;
         val_in = req_value;
         ptr_in = fill_ff;
      end
      if (cmd.load_era) begin
         ptr_in = FW'(req_position) + FW'(1);
      end
      if (cmd.load_list) begin
         ptr_in = '0;
      end

      // insert walks down: read ptr-1 now, write it to ptr in the next cycle
      if (cmd.ins_step) begin
         if (!stat.at_pos) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(ptr_ff - FW'(1));
            rd_vld_in = 1'b1;
            ptr_in    = ptr_ff - FW'(1);
         end
         if (rd_vld_ff) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(ptr_ff + FW'(1));
         end
      end

      if (cmd.ins_put) begin
         ram_we    = 1'b1;
         ram_waddr = AW'(pos_ff);
         ram_wdata = val_ff;
         fill_in   = fill_ff + FW'(1);
         strobe_in = 1'b1;
         ok_in     = 1'b1;
         cnt_in    = CNT_W'(fill_ff + FW'(1));
         item_in   = '0;
         ivld_in   = 1'b0;
         last_in   = 1'b1;
      end

      // erase walks up: read ptr now, write it to ptr-1 in the next cycle
      if (cmd.era_step) begin
         if (!stat.at_fill) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(ptr_ff);
            rd_vld_in = 1'b1;
            ptr_in    = ptr_ff + FW'(1);
         end
         if (rd_vld_ff) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(ptr_ff - FW'(2));
         end
         if (stat.at_fill) begin
            fill_in   = fill_ff - FW'(1);
            strobe_in = 1'b1;
            ok_in     = 1'b1;
            cnt_in    = CNT_W'(fill_ff - FW'(1));
            item_in   = '0;
            ivld_in   = 1'b0;
            last_in   = 1'b1;
         end
      end

      if (cmd.list_step) begin
         if (!stat.at_fill) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(ptr_ff);
            rd_vld_in = 1'b1;
            ptr_in    = ptr_ff + FW'(1);
         end
         if (rd_vld_ff) begin
            strobe_in = 1'b1;
            ok_in     = 1'b1;
            cnt_in    = CNT_W'(fill_ff);
            item_in   = ram_rdata;
            ivld_in   = 1'b1;
            last_in   = stat.at_fill;
         end
      end

      if (cmd.rsp_fail || cmd.rsp_empty) begin
         strobe_in = 1'b1;
         ok_in     = cmd.rsp_empty;
         cnt_in    = CNT_W'(fill_ff);
         item_in   = '0;
         ivld_in   = 1'b0;
         last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         rd_vld_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         rd_vld_ff <= rd_vld_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      ok_ff   <= ok_in;
      cnt_ff  <= cnt_in;
      item_ff <= item_in;
      ivld_ff <= ivld_in;
      last_ff <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_count      = cnt_ff;
   assign rsp_item       = item_ff;
   assign rsp_item_valid = ivld_ff;
   assign rsp_last       = last_ff;

endmodule

>>> rtl/indexed_insert_erase_list_top.sv
// ----------------------------------------------------------------------------
// indexed_insert_erase_list_top
// Ordered list of signed words with insert, erase and list requests.
//
//   channel   handshake            payload
//   request   start / busy         req_func, req_position, req_value
//   result    rsp_strobe           rsp_ok, rsp_count, rsp_item,
//                                  rsp_item_valid, rsp_last
//
// insert, erase and list each make one pass over the entry ram.
// a rejected request or an empty list answers in the cycle after acceptance.
// reset empties the list at once; no clearing pass is needed.
// results leave one per cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module indexed_insert_erase_list_top
   import ila_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_strobe,
   output logic                     rsp_ok,
   output logic [CNT_W-1:0]         rsp_count,
   output logic signed [DATA_W-1:0] rsp_item,
   output logic                     rsp_item_valid,
   output logic                     rsp_last
);

   ctl_cmd_type   cmd;
   dp_status_type stat;

   ila_ctl u_ctl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   ila_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .stat           (stat),
      .rsp_strobe     (rsp_strobe),
      .rsp_ok         (rsp_ok),
      .rsp_count      (rsp_count),
      .rsp_item       (rsp_item),
      .rsp_item_valid (rsp_item_valid),
      .rsp_last       (rsp_last)
   );

   // an accepted request either starts a walk or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted request neither busy nor answered");

   // list results come back to back until the last one
   a_list_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a list burst");

   a_item_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item_valid |-> rsp_ok)
      else $error("stored entry returned on a failed request");

   a_no_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item_valid |-> rsp_last && rsp_item == '0)
      else $error("result without entry is not a final zero result");

endmodule
